>>> rtl/upr_pkg.sv
// Package for the ultrasonic parking ranger: phase and pattern types, register
// indexes, configuration and result structs, and the distance and buzzer helpers.
// No dependencies.
package upr_pkg;

  typedef enum logic [2:0] {
    PH_BUZZ    = 3'd0,
    PH_TRIG    = 3'd1,
    PH_WAIT    = 3'd2,
    PH_COUNT   = 3'd3,
    PH_RECOVER = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    PAT_SOLID = 3'd0,
    PAT_FAST  = 3'd1,
    PAT_MID   = 3'd2,
    PAT_SLOW  = 3'd3,
    PAT_NONE  = 3'd4
  } pat_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER = 3'd5;

  localparam logic [7:0]  DIST_SOLID = 8'd5;
  localparam logic [7:0]  DIST_FAST  = 8'd10;
  localparam logic [7:0]  DIST_MID   = 8'd20;
  localparam logic [7:0]  DIST_SLOW  = 8'd30;
  localparam logic [15:0] ECHO_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [7:0]        trigger_ticks;
    logic [19:0]       beep_unit_ticks;
    logic [15:0]       timeout_ticks;
    logic [15:0]       scale_q16;
    logic signed [7:0] calib_offset;
    logic [19:0]       recover_ticks;
  } cfg_t;

  // The last member sits in the lowest bits.
  typedef struct packed {
    logic        timeout_error;
    logic        done_res;
    logic [15:0] echo_ticks;
    logic [7:0]  distance_cm;
    logic        buzzer;
    logic        trigger;
  } res_t;

  function automatic pat_t pat_of(input logic [7:0] dist_cm);
    pat_t p;
    if (dist_cm < DIST_SOLID) begin
      p = PAT_SOLID;
    end else if (dist_cm < DIST_FAST) begin
      p = PAT_FAST;
    end else if (dist_cm < DIST_MID) begin
      p = PAT_MID;
    end else if (dist_cm < DIST_SLOW) begin
      p = PAT_SLOW;
    end else begin
      p = PAT_NONE;
    end
    return p;
  endfunction

  function automatic logic [4:0] pat_total(input pat_t p);
    logic [4:0] t;
    unique case (p)
      PAT_SOLID: t = 5'd16;
      PAT_FAST:  t = 5'd6;
      PAT_MID:   t = 5'd8;
      PAT_SLOW:  t = 5'd6;
      default:   t = 5'd0;
    endcase
    return t;
  endfunction

  function automatic logic toggle_due(input pat_t p, input logic [4:0] tc);
    logic due;
    unique case (p)
      PAT_FAST: due = 1'b1;
      PAT_MID:  due = ~tc[0];
      PAT_SLOW: due = (tc == 5'd0) || (tc == 5'd3) || (tc == 5'd6) || (tc == 5'd9) ||
                      (tc == 5'd12) || (tc == 5'd15) || (tc == 5'd18) || (tc == 5'd21) ||
                      (tc == 5'd24) || (tc == 5'd27) || (tc == 5'd30);
      default:  due = 1'b0;
    endcase
    return due;
  endfunction

  function automatic logic [7:0] dist_calc(input logic [15:0] cnt, input logic [15:0] scale,
                                           input logic signed [7:0] off);
    logic [31:0]        prod;
    logic signed [17:0] sum;
    logic [7:0]         d;
    prod = cnt * scale;
    sum  = signed'({2'b00, prod[31:16]}) + signed'({{10{off[7]}}, off});
    if (sum < 18'sd0) begin
      d = 8'd0;
    end else if (sum > 18'sd255) begin
      d = 8'd255;
    end else begin
      d = sum[7:0];
    end
    return d;
  endfunction

endpackage

>>> rtl/upr_engine.sv
// Phase sequencer of the parking ranger: buzzer pattern, trigger pulse, echo
// wait and count, recovery. Advances one tick per step. Depends on upr_pkg.
module upr_engine import upr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic echo,
  input  cfg_t cfg,
  output res_t res
);

  phase_t      phase_r, phase_nxt;
  logic [19:0] phase_count_r, phase_count_nxt;
  logic [4:0]  toggle_count_r, toggle_count_nxt;
  logic        buzz_r, buzz_nxt;
  logic [7:0]  dist_r, dist_nxt;
  logic [15:0] echo_cnt_r, echo_cnt_nxt;
  logic        err_r, err_nxt;

  pat_t        pat;
  logic [4:0]  total;
  logic [19:0] ulen;
  logic [7:0]  tlen;
  logic [20:0] pc_inc;
  logic [4:0]  tc_inc;
  logic        unit_end, buzz_last, trig_end, rec_end, cnt_over;
  logic [15:0] echo_inc;
  logic [7:0]  new_dist;

  always_comb begin
    pat       = pat_of(dist_r);
    total     = pat_total(pat);
    ulen      = (cfg.beep_unit_ticks == 20'd0) ? 20'd1 : cfg.beep_unit_ticks;
    tlen      = (cfg.trigger_ticks == 8'd0) ? 8'd1 : cfg.trigger_ticks;
    pc_inc    = {1'b0, phase_count_r} + 21'd1;
    tc_inc    = toggle_count_r + 5'd1;
    unit_end  = pc_inc >= {1'b0, ulen};
    buzz_last = unit_end && (tc_inc >= total);
    trig_end  = pc_inc >= {13'd0, tlen};
    rec_end   = pc_inc >= {1'b0, cfg.recover_ticks};
    echo_inc  = (echo_cnt_r != ECHO_MAX) ? echo_cnt_r + 16'd1 : echo_cnt_r;
    cnt_over  = (echo_inc > cfg.timeout_ticks) || (echo_inc == ECHO_MAX);
    new_dist  = dist_calc(echo_cnt_r, cfg.scale_q16, cfg.calib_offset);
  end

  always_comb begin
    phase_nxt        = phase_r;
    phase_count_nxt  = phase_count_r;
    toggle_count_nxt = toggle_count_r;
    buzz_nxt         = buzz_r;
    dist_nxt         = dist_r;
    echo_cnt_nxt     = echo_cnt_r;
    err_nxt          = err_r;
    unique case (phase_r)
      PH_BUZZ: begin
        if (total == 5'd0) begin
          phase_nxt        = PH_TRIG;
          phase_count_nxt  = 20'd0;
          toggle_count_nxt = 5'd0;
        end else begin
          if (phase_count_r == 20'd0) begin
            if (pat == PAT_SOLID) begin
              buzz_nxt = 1'b1;
            end else if (toggle_due(pat, toggle_count_r)) begin
              buzz_nxt = ~buzz_r;
            end
          end
          if (unit_end) begin
            phase_count_nxt  = 20'd0;
            toggle_count_nxt = tc_inc;
            if (buzz_last) begin
              if (pat == PAT_SOLID) begin
                buzz_nxt = 1'b0;
              end
              toggle_count_nxt = 5'd0;
              phase_nxt        = PH_TRIG;
            end
          end else begin
            phase_count_nxt = pc_inc[19:0];
          end
        end
      end
      PH_TRIG: begin
        if (trig_end) begin
          phase_count_nxt = 20'd0;
          phase_nxt       = PH_WAIT;
        end else begin
          phase_count_nxt = pc_inc[19:0];
        end
      end
      PH_WAIT: begin
        if (echo) begin
          echo_cnt_nxt = 16'd0;
          phase_nxt    = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (!echo) begin
          dist_nxt         = new_dist;
          err_nxt          = 1'b0;
          phase_nxt        = PH_BUZZ;
          phase_count_nxt  = 20'd0;
          toggle_count_nxt = 5'd0;
        end else begin
          echo_cnt_nxt = echo_inc;
          if (cnt_over) begin
            err_nxt          = 1'b1;
            phase_count_nxt  = 20'd0;
            toggle_count_nxt = 5'd0;
            phase_nxt        = (cfg.recover_ticks != 20'd0) ? PH_RECOVER : PH_BUZZ;
          end
        end
      end
      PH_RECOVER: begin
        if (rec_end) begin
          phase_count_nxt = 20'd0;
          phase_nxt       = PH_BUZZ;
        end else begin
          phase_count_nxt = pc_inc[19:0];
        end
      end
      default: begin
        phase_nxt        = PH_BUZZ;
        phase_count_nxt  = 20'd0;
        toggle_count_nxt = 5'd0;
      end
    endcase
  end

  always_comb begin
    res.trigger       = (phase_r == PH_TRIG);
    res.done_res      = (phase_r == PH_COUNT) && (!echo || cnt_over);
    res.buzzer        = buzz_nxt;
    res.distance_cm   = dist_nxt;
    res.echo_ticks    = echo_cnt_nxt;
    res.timeout_error = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_BUZZ;
      phase_count_r  <= 20'd0;
      toggle_count_r <= 5'd0;
      buzz_r         <= 1'b0;
      dist_r         <= 8'd255;
      echo_cnt_r     <= 16'd0;
      err_r          <= 1'b0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      phase_count_r  <= phase_count_nxt;
      toggle_count_r <= toggle_count_nxt;
      buzz_r         <= buzz_nxt;
      dist_r         <= dist_nxt;
      echo_cnt_r     <= echo_cnt_nxt;
      err_r          <= err_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res |=> (phase_r == PH_BUZZ) || (phase_r == PH_RECOVER))
    else $error("finished measurement did not leave the count phase");

  a_echo_start: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_WAIT) && echo |=> (echo_cnt_r == 16'd0) && (phase_r == PH_COUNT))
    else $error("echo rise did not start a fresh count");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(phase_count_r) && $stable(echo_cnt_r))
    else $error("sequencer state moved without a tick");

  a_solid_off: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_BUZZ) && (pat == PAT_SOLID) && buzz_last |=> !buzz_r)
    else $error("solid buzzer pattern not switched off at its end");

  a_toggle_range: assert property (@(posedge clk) disable iff (!rst_n)
    toggle_count_r < 5'd16)
    else $error("toggle count beyond the longest pattern");
`endif

endmodule

>>> rtl/ultrasonic_parking_ranger.sv
// Top level of the ultrasonic parking ranger: configuration registers, tick input
// register, sequencer and result register. Depends on upr_pkg and upr_engine.
//
//   Channel  Direction  Word                 Contents
//   in_      slave      in_tdata[7:0]        echo at bit 0
//   out_     master     out_tdata[31:0]      trigger, buzzer, distance, echo count, flags
//   cfg_     slave      cfg_index, cfg_data  one register write per word
//
// Each tick word passes the input register and then the sequencer into the result
// register; one word per cycle is sustained while the output is not stalled.
// The sequencer state advances only when a registered tick moves to the output.
// A stalled output holds its word; the input register still takes one more word.
// Reset restores the register defaults and starts in the buzzer phase at 255 cm.
module ultrasonic_parking_ranger import upr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] echo
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [0] trigger, [1] buzzer, [9:2] distance_cm,
                                            // [25:10] echo_ticks, [26] done_res,
                                            // [27] timeout_error
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  logic  s1_valid_r, s1_echo_r;
  logic  out_valid_r;
  res_t  out_res_r;
  res_t  res;
  logic  advance, step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks   <= 8'd15;
      cfg_r.beep_unit_ticks <= 20'd75000;
      cfg_r.timeout_ticks   <= 16'd14700;
      cfg_r.scale_q16       <= 16'd743;
      cfg_r.calib_offset    <= 8'sd0;
      cfg_r.recover_ticks   <= 20'd320000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TRIGGER: cfg_r.trigger_ticks   <= cfg_data[7:0];
        REG_BEEP:    cfg_r.beep_unit_ticks <= cfg_data;
        REG_TIMEOUT: cfg_r.timeout_ticks   <= cfg_data[15:0];
        REG_SCALE:   cfg_r.scale_q16       <= cfg_data[15:0];
        REG_OFFSET:  cfg_r.calib_offset    <= signed'(cfg_data[7:0]);
        REG_RECOVER: cfg_r.recover_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance   = !out_valid_r || out_tready;
  assign step      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_echo_r <= in_tdata[0];
    end
  end

  upr_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .echo  (s1_echo_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r};

endmodule

>>> dv/tb_top.sv
// Testbench for ultrasonic_parking_ranger: streams echo ticks, predicts each result word
// with its own model of the ranging sequencer and compares field by field.
// Depends on upr_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_top;
  import upr_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int SQUEEZE_CYCLES = 400;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'd0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TRIGGER;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ultrasonic_parking_ranger dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  class ranger_scoreboard;
    logic [7:0]        trig_len;
    logic [19:0]       unit_len;
    logic [15:0]       limit;
    logic [15:0]       scale;
    logic signed [7:0] offset;
    logic [19:0]       recover_len;
    phase_t            ph;
    logic [19:0]       ph_cnt;
    logic [4:0]        tog_cnt;
    logic              buzz;
    logic [7:0]        dist_cm;
    logic [15:0]       echo_cnt;
    logic              err;
    res_t              expected_words[$];
    int                errors;

    function new();
      trig_len = 8'd15;
      unit_len = 20'd75000;
      limit = 16'd14700;
      scale = 16'd743;
      offset = 8'sd0;
      recover_len = 20'd320000;
      ph = PH_BUZZ;
      ph_cnt = '0;
      tog_cnt = '0;
      buzz = 1'b0;
      dist_cm = 8'd255;
      echo_cnt = '0;
      err = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TRIGGER: trig_len = val[7:0];
        REG_BEEP:    unit_len = val;
        REG_TIMEOUT: limit = val[15:0];
        REG_SCALE:   scale = val[15:0];
        REG_OFFSET:  offset = val[7:0];
        REG_RECOVER: recover_len = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] range_cm(logic [15:0] cnt);
      logic [31:0] prod;
      int          d;
      prod = {16'd0, cnt} * {16'd0, scale};
      d = int'(prod[31:16]) + int'(offset);
      if (d < 0) d = 0;
      if (d > 255) d = 255;
      return d[7:0];
    endfunction

    function void note_tick(logic echo);
      res_t        w;
      logic [19:0] unit_eff;
      logic [7:0]  trig_eff;
      logic [4:0]  total;
      logic [4:0]  step;
      logic        solid;
      logic        trig;
      logic        fin;
      trig = 1'b0;
      fin = 1'b0;
      solid = 1'b0;
      total = 5'd0;
      step = 5'd1;
      case (ph)
        PH_BUZZ: begin
          unit_eff = (unit_len == 20'd0) ? 20'd1 : unit_len;
          if (dist_cm < DIST_SOLID) begin
            solid = 1'b1;
            total = 5'd16;
            step = 5'd16;
          end else if (dist_cm < DIST_FAST) begin
            total = 5'd6;
            step = 5'd1;
          end else if (dist_cm < DIST_MID) begin
            total = 5'd8;
            step = 5'd2;
          end else if (dist_cm < DIST_SLOW) begin
            total = 5'd6;
            step = 5'd3;
          end
          if (total == 5'd0) begin
            ph = PH_TRIG;
            ph_cnt = '0;
            tog_cnt = '0;
          end else begin
            if (ph_cnt == 20'd0) begin
              if (solid) buzz = 1'b1;
              else if (tog_cnt % step == 5'd0) buzz = ~buzz;
            end
            if (ph_cnt + 1 >= unit_eff) begin
              ph_cnt = '0;
              tog_cnt = tog_cnt + 5'd1;
              if (tog_cnt >= total) begin
                if (solid) buzz = 1'b0;
                tog_cnt = '0;
                ph = PH_TRIG;
              end
            end else begin
              ph_cnt = ph_cnt + 20'd1;
            end
          end
        end
        PH_TRIG: begin
          trig_eff = (trig_len == 8'd0) ? 8'd1 : trig_len;
          trig = 1'b1;
          if (ph_cnt + 1 >= trig_eff) begin
            ph_cnt = '0;
            ph = PH_WAIT;
          end else begin
            ph_cnt = ph_cnt + 20'd1;
          end
        end
        PH_WAIT: begin
          if (echo) begin
            echo_cnt = '0;
            ph = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (!echo) begin
            dist_cm = range_cm(echo_cnt);
            err = 1'b0;
            fin = 1'b1;
            ph = PH_BUZZ;
            ph_cnt = '0;
            tog_cnt = '0;
          end else begin
            if (echo_cnt != ECHO_MAX) echo_cnt = echo_cnt + 16'd1;
            if (echo_cnt > limit || echo_cnt == ECHO_MAX) begin
              err = 1'b1;
              fin = 1'b1;
              ph_cnt = '0;
              tog_cnt = '0;
              ph = (recover_len != 20'd0) ? PH_RECOVER : PH_BUZZ;
            end
          end
        end
        PH_RECOVER: begin
          ph_cnt = ph_cnt + 20'd1;
          if (ph_cnt >= recover_len) begin
            ph_cnt = '0;
            ph = PH_BUZZ;
          end
        end
        default: begin
          ph = PH_BUZZ;
          ph_cnt = '0;
          tog_cnt = '0;
        end
      endcase
      w.trigger = trig;
      w.buzzer = buzz;
      w.distance_cm = dist_cm;
      w.echo_ticks = echo_cnt;
      w.done_res = fin;
      w.timeout_error = err;
      expected_words.push_back(w);
    endfunction

    function void cmp_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $error("%s: expected %0d, got %0d", name, exp, got);
        errors++;
      end
    endfunction

    function void check_word(res_t got);
      res_t exp;
      if (expected_words.size() == 0) begin
        $error("result word with no expectation pending: %h", got);
        errors++;
        return;
      end
      exp = expected_words.pop_front();
      cmp_field("trigger", exp.trigger, got.trigger);
      cmp_field("buzzer", exp.buzzer, got.buzzer);
      cmp_field("distance_cm", exp.distance_cm, got.distance_cm);
      cmp_field("echo_ticks", exp.echo_ticks, got.echo_ticks);
      cmp_field("done_res", exp.done_res, got.done_res);
      cmp_field("timeout_error", exp.timeout_error, got.timeout_error);
    endfunction
  endclass

  ranger_scoreboard sb;

  logic [CFG_IDX_W-1:0] reg_ids[6] = '{REG_TRIGGER, REG_BEEP, REG_TIMEOUT, REG_SCALE,
                                       REG_OFFSET, REG_RECOVER};
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int noise_pct = 0;
  int width_lo = 0;
  int width_hi = 0;
  int width_far = 0;
  int width_goal = 0;
  int width_plan[$];
  bit squeeze_req = 1'b0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_word(res_t'(out_tdata[27:0]));
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic next_echo();
    logic e;
    case (sb.ph)
      PH_WAIT:  e = ($urandom_range(99) < 30);
      PH_COUNT: e = (sb.echo_cnt < width_goal);
      default:  e = 1'($urandom_range(1));
    endcase
    if ($urandom_range(99) < noise_pct) e = 1'($urandom_range(1));
    if (sb.ph == PH_WAIT && e) begin
      if (width_plan.size() != 0) width_goal = width_plan.pop_front();
      else if ($urandom_range(4) == 0) width_goal = $urandom_range(width_far, width_lo);
      else width_goal = $urandom_range(width_hi, width_lo);
    end
    return e;
  endfunction

  // Ends only once the sequencer sits waiting for echo, so that a new setting
  // never lands in the middle of a buzzer pattern or a recovery delay.
  task automatic feed_ticks(input int count);
    int   sent;
    logic fire;
    sent = 0;
    forever begin
      @(posedge clk);
      fire = in_tvalid && in_tready;
      if (fire) begin
        sb.note_tick(in_tdata[0]);
        sent++;
      end
      if (!in_tvalid || fire) begin
        if (sent >= count && sb.ph == PH_WAIT && width_plan.size() == 0) begin
          in_tvalid <= 1'b0;
          break;
        end
        if ($urandom_range(99) < tx_idle_pct) begin
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, next_echo()};
        end
      end
    end
  endtask

  task automatic drain();
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] trig, input logic [19:0] unit,
                              input logic [15:0] tmo, input logic [15:0] scl,
                              input logic signed [7:0] off, input logic [19:0] rec);
    logic [CFG_DATA_W-1:0] vals[6];
    vals = '{{12'd0, trig}, unit, {4'd0, tmo}, {4'd0, scl}, {12'd0, off}, rec};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_ids[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(reg_ids[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 7;
    rx_idle_pct = 87;
    feed_ticks(1);
    drain();

    // Pulse widths straddle every buzzer threshold and the timeout.
    program_regs(8'd1, 20'd1, 16'd40, 16'd65535, 8'sd0, 20'd3);
    width_plan = '{0, 5, 6, 10, 11, 20, 21, 30, 31, 40, 41, 3};
    feed_ticks(1);
    drain();

    program_regs(8'd3, 20'd2, 16'd45, 16'd65535, 8'sd0, 20'd10);
    noise_pct = 5;
    width_lo = 0;
    width_hi = 50;
    width_far = 50;
    feed_ticks(30);
    drain();

    tx_idle_pct = 87;
    rx_idle_pct = 7;
    program_regs(8'd0, 20'd0, 16'd1, 16'd40000, -8'sd128, 20'd0);
    width_hi = 3;
    width_far = 3;
    feed_ticks(20);
    drain();

    program_regs(8'd255, 20'd1048575, 16'd65535, 16'd0, 8'sd127, 20'd1048575);
    width_hi = 60;
    width_far = 60;
    feed_ticks(30);
    drain();

    // A timeout with no recovery delay returns straight to the buzzer phase.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_regs(8'd2, 20'd1, 16'd20, 16'd65535, 8'sd5, 20'd0);
    noise_pct = 0;
    width_plan = '{25};
    feed_ticks(1);
    drain();

    program_regs(8'd4, 20'd3, 16'd50, 16'd65535, -8'sd30, 20'd7);
    noise_pct = 5;
    width_hi = 40;
    width_far = 60;
    squeeze_req = 1'b1;
    feed_ticks(40);
    drain();

    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
